// ----- rtl/core/ipfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfp_pkg
// Shared constants, register indexes and saturating helpers for the
// pixel-to-field back-projection pipeline.
// ----------------------------------------------------------------------------
package ipfp_pkg;

  localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q30   = 64'sh0000_0000_4000_0000;
  localparam logic [63:0]        QUAT_RESET = 64'h4000_0000_0000_0000;
  localparam logic [23:0]        FOCAL_RESET = 24'd256;

  typedef enum logic [3:0] {
    REG_ROTATION_QUAT    = 4'd0,
    REG_CAMERA_ORIGIN_X  = 4'd1,
    REG_CAMERA_ORIGIN_Y  = 4'd2,
    REG_CAMERA_ORIGIN_Z  = 4'd3,
    REG_DISTORTION_COEFF = 4'd4,
    REG_FOCAL_LEN        = 4'd5,
    REG_PRINCIPAL_X      = 4'd6,
    REG_PRINCIPAL_Y      = 4'd7
  } cfg_reg_t;

  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? INT64_MIN : INT64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if ((&v[63:31]) || !(|v[63:31])) begin
      return v[31:0];
    end
    return v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

// ----- rtl/core/ipfp_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfp_mul
// Pipelined signed 64x64 multiply, shift right by SHIFT with magnitude
// truncation, saturated to 64 bits. Four 32x32 partial products.
// ----------------------------------------------------------------------------
module ipfp_mul #(
  parameter int SHIFT = 30
) (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  logic         neg1, neg2, neg3;
  logic [63:0]  ma, mb;
  logic [63:0]  pp0, pp1, pp2, pp3;
  logic [127:0] prod;
  logic [63:0]  mag;
  logic         ovf;
  logic signed [63:0] p_next;

  always_ff @(posedge clk) begin
    neg1 <= a[63] ^ b[63];
    ma   <= a[63] ? (64'd0 - 64'(a)) : 64'(a);
    mb   <= b[63] ? (64'd0 - 64'(b)) : 64'(b);
    neg2 <= neg1;
    pp0  <= ma[31:0]  * mb[31:0];
    pp1  <= ma[31:0]  * mb[63:32];
    pp2  <= ma[63:32] * mb[31:0];
    pp3  <= ma[63:32] * mb[63:32];
    neg3 <= neg2;
    prod <= {pp3, pp0} + {32'd0, pp1, 32'd0} + {32'd0, pp2, 32'd0};
    p    <= p_next;
  end

  always_comb begin
    ovf = |prod[127:64+SHIFT];
    mag = prod[63+SHIFT:SHIFT];
    if (ovf) begin
      p_next = neg3 ? ipfp_pkg::INT64_MIN : ipfp_pkg::INT64_MAX;
    end else if (neg3) begin
      p_next = mag[63] ? ipfp_pkg::INT64_MIN : $signed(64'd0 - mag);
    end else begin
      p_next = mag[63] ? ipfp_pkg::INT64_MAX : $signed(mag);
    end
  end

endmodule

// ----- rtl/core/ipfp_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfp_div
// Pipelined signed divider, truncating toward zero. Restoring division,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module ipfp_div #(
  parameter int NW = 52,
  parameter int DW = 25
) (
  input  logic               clk,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [NW:0]   quo
);

  logic [NW-1:0] nsh [NW+1];
  logic [NW-1:0] qv  [NW+1];
  logic [DW-1:0] rem [NW+1];
  logic [DW-1:0] dv  [NW+1];
  logic          sg  [NW+1];

  always_ff @(posedge clk) begin
    nsh[0] <= num[NW-1] ? (NW'(0) - NW'(num)) : NW'(num);
    dv[0]  <= den[DW-1] ? (DW'(0) - DW'(den)) : DW'(den);
    rem[0] <= '0;
    qv[0]  <= '0;
    sg[0]  <= num[NW-1] ^ den[DW-1];
  end

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        take;

    always_comb begin
      trial = {rem[k-1], nsh[k-1][NW-1]};
      take  = (trial >= {1'b0, dv[k-1]});
    end

    always_ff @(posedge clk) begin
      rem[k] <= take ? DW'(trial - {1'b0, dv[k-1]}) : trial[DW-1:0];
      nsh[k] <= nsh[k-1] << 1;
      qv[k]  <= {qv[k-1][NW-2:0], take};
      dv[k]  <= dv[k-1];
      sg[k]  <= sg[k-1];
    end
  end

  always_ff @(posedge clk) begin
    quo <= sg[NW] ? -$signed({1'b0, qv[NW]}) : $signed({1'b0, qv[NW]});
  end

endmodule

// ----- rtl/core/image_pixel_to_field_point.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_pixel_to_field_point
// Back-projects a distorted pixel onto a horizontal plane in the field frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item transfers on a clock edge with start high and busy low.
//   busy stays low, so one item can enter every cycle.
//   Output: result_valid strobes for one cycle with field_x/y/z and no_hit.
//   Results leave in input order. Two long divider levels dominate the
//   path: 54 stages for the normalized point, 65 stages for the plane
//   distance, plus five 4-stage multiply levels and a few add/saturate
//   registers.
//   Throughput: one item per cycle, sustained.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write only while no item is in flight.
//   Reset (rst, synchronous) clears the registers to identity rotation,
//   zero origin and distortion, focal length 256, and drops all items in
//   flight. The receiver cannot stall; no backpressure exists.
// ----------------------------------------------------------------------------
module image_pixel_to_field_point (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [20:0]        pixel_x,
  input  logic [20:0]        pixel_y,
  input  logic signed [23:0] plane_height,
  output logic               result_valid,
  output logic signed [31:0] field_x,
  output logic signed [31:0] field_y,
  output logic signed [31:0] field_z,
  output logic               no_hit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int LAT_MUL  = 4;
  localparam int NW_A     = 52;
  localparam int NW_T     = 63;
  localparam int LAT_DIVA = NW_A + 2;
  localparam int LAT_DIVT = NW_T + 2;
  localparam int S_IN  = 1;
  localparam int S_AB  = S_IN + LAT_DIVA;
  localparam int S_R2  = S_AB + LAT_MUL + 1;
  localparam int S_S   = S_R2 + LAT_MUL + 1;
  localparam int S_AB2 = S_S + LAT_MUL;
  localparam int S_SUM = S_AB2 + LAT_MUL + 2;
  localparam int S_T   = S_SUM + LAT_DIVT;
  localparam int S_OUT = S_T + LAT_MUL + 1;
  localparam int D_AB  = S_S - S_AB;
  localparam int D_HOZ = S_SUM - S_IN;

  // configuration registers
  logic [63:0]        rotation_quat;
  logic signed [31:0] camera_origin_x, camera_origin_y, camera_origin_z;
  logic signed [31:0] distortion_coeff;
  logic [23:0]        focal_len;
  logic [20:0]        principal_x, principal_y;

  logic accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_quat    <= ipfp_pkg::QUAT_RESET;
      camera_origin_x  <= '0;
      camera_origin_y  <= '0;
      camera_origin_z  <= '0;
      distortion_coeff <= '0;
      focal_len        <= ipfp_pkg::FOCAL_RESET;
      principal_x      <= '0;
      principal_y      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ipfp_pkg::REG_ROTATION_QUAT:    rotation_quat    <= cfg_data;
        ipfp_pkg::REG_CAMERA_ORIGIN_X:  camera_origin_x  <= cfg_data[31:0];
        ipfp_pkg::REG_CAMERA_ORIGIN_Y:  camera_origin_y  <= cfg_data[31:0];
        ipfp_pkg::REG_CAMERA_ORIGIN_Z:  camera_origin_z  <= cfg_data[31:0];
        ipfp_pkg::REG_DISTORTION_COEFF: distortion_coeff <= cfg_data[31:0];
        ipfp_pkg::REG_FOCAL_LEN:        focal_len        <= cfg_data[23:0];
        ipfp_pkg::REG_PRINCIPAL_X:      principal_x      <= cfg_data[20:0];
        ipfp_pkg::REG_PRINCIPAL_Y:      principal_y      <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  // rotation matrix, Q.28, registered after the quaternion products
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [63:0] m00, m01, m02, m10, m11, m12, m20x4, m21x4, m22x4;

  assign qw = rotation_quat[63:48];
  assign qx = rotation_quat[47:32];
  assign qy = rotation_quat[31:16];
  assign qz = rotation_quat[15:0];

  always_ff @(posedge clk) begin
    ww <= qw * qw;
    xx <= qx * qx;
    yy <= qy * qy;
    zz <= qz * qz;
    xy <= qx * qy;
    wz <= qw * qz;
    xz <= qx * qz;
    wy <= qw * qy;
    yz <= qy * qz;
    wx <= qw * qx;
    m00   <= 64'(ww) + 64'(xx) - 64'(yy) - 64'(zz);
    m11   <= 64'(ww) - 64'(xx) + 64'(yy) - 64'(zz);
    m22x4 <= (64'(ww) - 64'(xx) - 64'(yy) + 64'(zz)) <<< 2;
    m01   <= (64'(xy) - 64'(wz)) <<< 1;
    m10   <= (64'(xy) + 64'(wz)) <<< 1;
    m02   <= (64'(xz) + 64'(wy)) <<< 1;
    m20x4 <= (64'(xz) - 64'(wy)) <<< 3;
    m12   <= (64'(yz) - 64'(wx)) <<< 1;
    m21x4 <= (64'(yz) + 64'(wx)) <<< 3;
  end

  // valid bits
  logic [S_OUT-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[S_OUT-2:0], accept};
    end
  end

  assign result_valid = vpipe[S_OUT-1];

  // input stage
  logic signed [21:0] dx, dy;
  logic signed [32:0] hoz;
  logic [23:0]        f_eff;

  always_ff @(posedge clk) begin
    dx  <= $signed({1'b0, pixel_x}) - $signed({1'b0, principal_x});
    dy  <= $signed({1'b0, pixel_y}) - $signed({1'b0, principal_y});
    hoz <= 33'(plane_height) - 33'(camera_origin_z);
  end

  assign f_eff = (focal_len == '0) ? 24'd1 : focal_len;

  // normalized point
  logic signed [NW_A:0] a_q, b_q;

  ipfp_div #(.NW(NW_A), .DW(25)) u_div_a (
    .clk (clk),
    .num ({dx, 30'd0}),
    .den ($signed({1'b0, f_eff})),
    .quo (a_q)
  );

  ipfp_div #(.NW(NW_A), .DW(25)) u_div_b (
    .clk (clk),
    .num ({dy, 30'd0}),
    .den ($signed({1'b0, f_eff})),
    .quo (b_q)
  );

  logic signed [63:0] a64, b64, aa, bb, r2, dr, s_q30;

  assign a64 = 64'(a_q);
  assign b64 = 64'(b_q);

  ipfp_mul #(.SHIFT(30)) u_mul_aa (.clk(clk), .a(a64), .b(a64), .p(aa));
  ipfp_mul #(.SHIFT(30)) u_mul_bb (.clk(clk), .a(b64), .b(b64), .p(bb));

  always_ff @(posedge clk) begin
    r2 <= ipfp_pkg::add_sat64(aa, bb);
  end

  ipfp_mul #(.SHIFT(30)) u_mul_dr (
    .clk (clk),
    .a   (64'(distortion_coeff)),
    .b   (r2),
    .p   (dr)
  );

  always_ff @(posedge clk) begin
    s_q30 <= ipfp_pkg::add_sat64(ipfp_pkg::ONE_Q30, dr);
  end

  // a, b wait for the undistortion scale
  logic signed [63:0] a_dl [D_AB];
  logic signed [63:0] b_dl [D_AB];

  always_ff @(posedge clk) begin
    a_dl[0] <= a64;
    b_dl[0] <= b64;
    for (int i = 1; i < D_AB; i++) begin
      a_dl[i] <= a_dl[i-1];
      b_dl[i] <= b_dl[i-1];
    end
  end

  logic signed [63:0] ua, ub;

  ipfp_mul #(.SHIFT(30)) u_mul_as (.clk(clk), .a(a_dl[D_AB-1]), .b(s_q30), .p(ua));
  ipfp_mul #(.SHIFT(30)) u_mul_bs (.clk(clk), .a(b_dl[D_AB-1]), .b(s_q30), .p(ub));

  // ray = M^T * (a, b, 1)
  logic signed [63:0] p00, p10, p01, p11, p02, p12;
  logic signed [63:0] sx, sy, sz, rx, ry, rz;

  ipfp_mul #(.SHIFT(28)) u_mul_00 (.clk(clk), .a(m00), .b(ua), .p(p00));
  ipfp_mul #(.SHIFT(28)) u_mul_10 (.clk(clk), .a(m10), .b(ub), .p(p10));
  ipfp_mul #(.SHIFT(28)) u_mul_01 (.clk(clk), .a(m01), .b(ua), .p(p01));
  ipfp_mul #(.SHIFT(28)) u_mul_11 (.clk(clk), .a(m11), .b(ub), .p(p11));
  ipfp_mul #(.SHIFT(28)) u_mul_02 (.clk(clk), .a(m02), .b(ua), .p(p02));
  ipfp_mul #(.SHIFT(28)) u_mul_12 (.clk(clk), .a(m12), .b(ub), .p(p12));

  always_ff @(posedge clk) begin
    sx <= ipfp_pkg::add_sat64(p00, p10);
    sy <= ipfp_pkg::add_sat64(p01, p11);
    sz <= ipfp_pkg::add_sat64(p02, p12);
    rx <= ipfp_pkg::add_sat64(sx, m20x4);
    ry <= ipfp_pkg::add_sat64(sy, m21x4);
    rz <= ipfp_pkg::add_sat64(sz, m22x4);
  end

  // plane offset waits for the ray
  logic signed [32:0] hoz_dl [D_HOZ];

  always_ff @(posedge clk) begin
    hoz_dl[0] <= hoz;
    for (int i = 1; i < D_HOZ; i++) begin
      hoz_dl[i] <= hoz_dl[i-1];
    end
  end

  logic signed [NW_T:0] t_q;

  ipfp_div #(.NW(NW_T), .DW(64)) u_div_t (
    .clk (clk),
    .num ({hoz_dl[D_HOZ-1], 30'd0}),
    .den (rz),
    .quo (t_q)
  );

  // ray waits for t
  logic signed [63:0] rx_dl [LAT_DIVT];
  logic signed [63:0] ry_dl [LAT_DIVT];
  logic signed [63:0] rz_dl [LAT_DIVT];
  logic               nh_dl [LAT_DIVT + LAT_MUL];

  always_ff @(posedge clk) begin
    rx_dl[0] <= rx;
    ry_dl[0] <= ry;
    rz_dl[0] <= rz;
    nh_dl[0] <= (rz == '0);
    for (int i = 1; i < LAT_DIVT; i++) begin
      rx_dl[i] <= rx_dl[i-1];
      ry_dl[i] <= ry_dl[i-1];
      rz_dl[i] <= rz_dl[i-1];
    end
    for (int i = 1; i < LAT_DIVT + LAT_MUL; i++) begin
      nh_dl[i] <= nh_dl[i-1];
    end
  end

  logic signed [63:0] ox_t, oy_t, oz_t;

  ipfp_mul #(.SHIFT(30)) u_mul_xt (.clk(clk), .a(rx_dl[LAT_DIVT-1]), .b(t_q), .p(ox_t));
  ipfp_mul #(.SHIFT(30)) u_mul_yt (.clk(clk), .a(ry_dl[LAT_DIVT-1]), .b(t_q), .p(oy_t));
  ipfp_mul #(.SHIFT(30)) u_mul_zt (.clk(clk), .a(rz_dl[LAT_DIVT-1]), .b(t_q), .p(oz_t));

  logic nh_last;

  assign nh_last = nh_dl[LAT_DIVT + LAT_MUL - 1];

  always_ff @(posedge clk) begin
    if (nh_last) begin
      field_x <= '0;
      field_y <= '0;
      field_z <= '0;
    end else begin
      field_x <= ipfp_pkg::sat32(ipfp_pkg::add_sat64(64'(camera_origin_x), ox_t));
      field_y <= ipfp_pkg::sat32(ipfp_pkg::add_sat64(64'(camera_origin_y), oy_t));
      field_z <= ipfp_pkg::sat32(ipfp_pkg::add_sat64(64'(camera_origin_z), oz_t));
    end
    no_hit <= nh_last;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##S_OUT result_valid)
    else $error("result strobe missing at fixed latency");

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && no_hit) |-> (field_x == '0 && field_y == '0 && field_z == '0))
    else $error("no_hit result carries nonzero coordinates");

  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result strobe right after reset");
`endif

endmodule
